[rtl/assert_macros.svh]
// Assertion macros for the RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_CLK(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Implication checked every cycle outside reset.
`define ASSERT_IMPL(lbl, ck, rstn, pre, post, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (pre) |-> (post)) else $error(msg);

`endif

[rtl/sba_pkg.sv]
// Types, constants and helpers for the spectrum band averager.
// No dependencies.
`default_nettype none

package sba_pkg;

	localparam int BAND_COUNT = 12;
	localparam int BAND_W     = 4;
	localparam int POS_W      = 10;
	localparam int MAG_W      = 15;
	localparam int SUM_W      = 23;
	localparam int AVG_W      = 16;
	localparam int RCP_W      = 31;
	localparam int RCP_SHIFT  = 31;

	localparam logic [POS_W-1:0]  POS_MAX   = '1;
	localparam logic [BAND_W-1:0] BAND_LAST = BAND_W'(BAND_COUNT - 1);

	localparam logic [POS_W-1:0] BAND_EDGE [BAND_COUNT+1] = '{
		10'd6, 10'd8, 10'd11, 10'd16, 10'd24, 10'd35, 10'd51,
		10'd75, 10'd110, 10'd161, 10'd237, 10'd349, 10'd513
	};

	// ceil(2^31 / d) for band divisors 2, 3, 5, 8, 11, 16, 24, 35, 51, 76, 112, 163;
	// (sum * r) >> 31 is the truncated quotient for any 23-bit sum
	localparam logic [RCP_W-1:0] BAND_RECIP [BAND_COUNT] = '{
		31'd1073741824, 31'd715827883, 31'd429496730, 31'd268435456,
		31'd195225787, 31'd134217728, 31'd89478486, 31'd61356676,
		31'd42107523, 31'd28256364, 31'd19173962, 31'd13174747
	};

	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		logic             frame_end;
	} bin_t;

	typedef struct packed {
		logic [BAND_W-1:0] band;
		logic [AVG_W-1:0]  band_average;
		logic              band_last;
	} avg_t;

	typedef enum logic [1:0] {
		ST_ACC,
		ST_FLUSH,
		ST_LOAD,
		ST_PUT
	} state_t;

	typedef struct packed {
		logic              acc;
		logic              flush;
		logic              load;
		logic              put;
		logic [BAND_W-1:0] emit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic              hit;
		logic [BAND_W-1:0] idx;
	} band_sel_t;

	function automatic band_sel_t band_of(input logic [POS_W-1:0] pos);
		band_sel_t r;
		r.hit = 1'b0;
		r.idx = '0;
		for (int k = 0; k < BAND_COUNT; k++) begin
			if (pos >= BAND_EDGE[k] && pos < BAND_EDGE[k+1]) begin
				r.hit = 1'b1;
				r.idx = BAND_W'(k);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/sba_ctrl.sv]
// Controller: frame sequencing, per-band divide and emit steps.
// Depends on sba_pkg.
`default_nettype none

module sba_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          bin_valid,
	input  wire logic          frame_end,
	output logic               bin_stall,
	input  wire sba_pkg::sts_t sts,
	output sba_pkg::cmd_t      cmd
);
	import sba_pkg::*;

	state_t             state_q, state_nx;
	logic [BAND_W-1:0]  emit_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_ACC: begin
				if (bin_valid && frame_end)
					state_nx = ST_FLUSH;
			end
			ST_FLUSH: state_nx = ST_LOAD;
			ST_LOAD:  state_nx = ST_PUT;
			ST_PUT: begin
				if (sts.out_free)
					state_nx = (emit_q == BAND_LAST) ? ST_ACC : ST_LOAD;
			end
			default: state_nx = ST_ACC;
		endcase
	end

	always_comb begin
		bin_stall = 1'b1;
		cmd       = '0;
		cmd.emit  = emit_q;
		case (state_q)
			ST_ACC: begin
				bin_stall = 1'b0;
				cmd.acc   = bin_valid;
			end
			ST_FLUSH: cmd.flush = 1'b1;
			ST_LOAD:  cmd.load  = 1'b1;
			ST_PUT:   cmd.put   = sts.out_free;
			default:  cmd       = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			emit_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (cmd.put)
				emit_q <= (emit_q == BAND_LAST) ? '0 : emit_q + BAND_W'(1);
		end
	end

endmodule

`default_nettype wire

[rtl/sba_datapath.sv]
// Datapath: bin counter, band accumulator, band sum bank, reciprocal divider,
// output register. Depends on sba_pkg.
`default_nettype none

module sba_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sba_pkg::cmd_t cmd,
	input  wire sba_pkg::bin_t bin,
	output sba_pkg::sts_t      sts,
	output logic               avg_valid,
	input  wire logic          avg_stall,
	output sba_pkg::avg_t      avg
);
	import sba_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [BAND_W-1:0] cur_q;
	logic              acc_vld_q;
	logic [SUM_W-1:0]  acc_q;
	logic [SUM_W-1:0]  sums_q [BAND_COUNT];
	logic              sum_vld_q [BAND_COUNT];
	logic [AVG_W-1:0]  quo_q;
	logic              out_vld_q;
	avg_t              avg_q;

	band_sel_t              sel;
	logic                   new_band;
	logic                   bank_wr;
	logic [SUM_W-1:0]       dividend;
	logic [SUM_W+RCP_W-1:0] prod;

	assign sel      = band_of(pos_q);
	assign new_band = cmd.acc && sel.hit && !(acc_vld_q && sel.idx == cur_q);
	assign bank_wr  = acc_vld_q && (new_band || cmd.flush);
	assign dividend = sum_vld_q[cmd.emit] ? sums_q[cmd.emit] : '0;
	assign prod     = dividend * BAND_RECIP[cmd.emit];

	assign sts.out_free = !out_vld_q || !avg_stall;
	assign avg_valid    = out_vld_q;
	assign avg          = avg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			cur_q     <= '0;
			acc_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
			for (int k = 0; k < BAND_COUNT; k++)
				sum_vld_q[k] <= 1'b0;
		end else begin
			if (cmd.acc) begin
				if (pos_q != POS_MAX)
					pos_q <= pos_q + POS_W'(1);
				if (new_band) begin
					cur_q     <= sel.idx;
					acc_vld_q <= 1'b1;
				end
			end
			if (cmd.flush) begin
				pos_q     <= '0;
				acc_vld_q <= 1'b0;
			end
			if (bank_wr)
				sum_vld_q[cur_q] <= 1'b1;
			if (cmd.load)
				sum_vld_q[cmd.emit] <= 1'b0;
			if (cmd.put)
				out_vld_q <= 1'b1;
			else if (!avg_stall)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc && sel.hit)
			acc_q <= new_band ? SUM_W'(bin.magnitude) : acc_q + SUM_W'(bin.magnitude);
		if (bank_wr)
			sums_q[cur_q] <= acc_q;
		if (cmd.load)
			quo_q <= prod[RCP_SHIFT+AVG_W-1:RCP_SHIFT];
		if (cmd.put) begin
			avg_q.band         <= cmd.emit;
			avg_q.band_average <= quo_q;
			avg_q.band_last    <= (cmd.emit == BAND_LAST);
		end
	end

endmodule

`default_nettype wire

[rtl/spectrum_band_averager.sv]
// Spectrum band averager, top level. Bins are taken one per cycle while not stalled.
// A frame-end beat stalls the bin input through one flush step, then per band one load
// (reciprocal multiply) and one put; a put waits while the output is stalled.
// Async active-low reset clears the bin counter, the output valid and the valid flags
// of the accumulator and band sums.
// Depends on sba_pkg, sba_ctrl, sba_datapath, assert_macros.svh.
`default_nettype none

module spectrum_band_averager (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          bin_valid,
	output logic               bin_stall,
	input  wire sba_pkg::bin_t bin,
	output logic               avg_valid,
	input  wire logic          avg_stall,
	output sba_pkg::avg_t      avg
);
	import sba_pkg::*;

	`include "assert_macros.svh"

	cmd_t cmd;
	sts_t sts;

	sba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.bin_valid (bin_valid),
		.frame_end (bin.frame_end),
		.bin_stall (bin_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sba_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.bin       (bin),
		.sts       (sts),
		.avg_valid (avg_valid),
		.avg_stall (avg_stall),
		.avg       (avg)
	);

	`ASSERT_IMPL(a_last_is_top_band, clk, arst_n, avg_valid && avg.band_last, avg.band == BAND_LAST, "band_last on wrong band")
	`ASSERT_CLK(a_frame_end_stalls, clk, arst_n, bin_valid && !bin_stall && bin.frame_end |=> bin_stall, "bins taken after frame end")
	`ASSERT_IMPL(a_avg_range, clk, arst_n, avg_valid, avg.band_average <= 16'd32968, "band average out of range")
	`ASSERT_IMPL(a_one_cmd, clk, arst_n, 1'b1, $onehot0({cmd.acc, cmd.flush, cmd.load, cmd.put}), "overlapping datapath commands")

endmodule

`default_nettype wire

[tb/sv/sba_band_checker.sv]
// Checker for the spectrum band averager: follows bin beats, predicts the twelve
// band averages of each frame and compares every result beat in order.
// Depends on sba_pkg.
`default_nettype none

module sba_band_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          bin_valid,
	input  wire logic          bin_stall,
	input  wire sba_pkg::bin_t bin,
	input  wire logic          avg_valid,
	input  wire logic          avg_stall,
	input  wire sba_pkg::avg_t avg,
	output int                 fail_count,
	output int                 pending,
	output int                 checked
);
	import sba_pkg::*;

	logic [9:0]  next_bin;
	logic [22:0] band_acc [12];
	avg_t        expected_avgs [$];

	// -1: bin belongs to no band
	function automatic int band_of_bin(input logic [9:0] p);
		if (p < 10'd6)
			return -1;
		else if (p < 10'd8)
			return 0;
		else if (p < 10'd11)
			return 1;
		else if (p < 10'd16)
			return 2;
		else if (p < 10'd24)
			return 3;
		else if (p < 10'd35)
			return 4;
		else if (p < 10'd51)
			return 5;
		else if (p < 10'd75)
			return 6;
		else if (p < 10'd110)
			return 7;
		else if (p < 10'd161)
			return 8;
		else if (p < 10'd237)
			return 9;
		else if (p < 10'd349)
			return 10;
		else if (p < 10'd513)
			return 11;
		return -1;
	endfunction

	function automatic int band_divisor(input int k);
		case (k)
			0: return 2;
			1: return 3;
			2: return 5;
			3: return 8;
			4: return 11;
			5: return 16;
			6: return 24;
			7: return 35;
			8: return 51;
			9: return 76;
			10: return 112;
			default: return 163;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		int   b;
		avg_t e;
		if (!arst_n) begin
			next_bin = '0;
			for (int k = 0; k < 12; k++)
				band_acc[k] = '0;
			expected_avgs.delete();
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
		end else begin
			if (avg_valid && !avg_stall) begin
				if (expected_avgs.size() == 0) begin
					$display("%0t: unexpected band result: band %0d avg %0d last %0b",
						$time, avg.band, avg.band_average, avg.band_last);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_avgs.pop_front();
					if (avg.band !== e.band || avg.band_average !== e.band_average ||
						avg.band_last !== e.band_last) begin
						$display("%0t: band result mismatch: expected band %0d avg %0d last %0b, got band %0d avg %0d last %0b",
							$time, e.band, e.band_average, e.band_last,
							avg.band, avg.band_average, avg.band_last);
						fail_count <= fail_count + 1;
					end
					checked <= checked + 1;
				end
			end
			if (bin_valid && !bin_stall) begin
				b = band_of_bin(next_bin);
				if (b >= 0)
					band_acc[b] = band_acc[b] + bin.magnitude;
				if (next_bin != 10'h3FF)
					next_bin = next_bin + 10'd1;
				if (bin.frame_end) begin
					for (int k = 0; k < 12; k++) begin
						e.band         = 4'(k);
						e.band_average = 16'(band_acc[k] / band_divisor(k));
						e.band_last    = (k == BAND_COUNT - 1);
						expected_avgs.push_back(e);
						band_acc[k] = '0;
					end
					next_bin = '0;
				end
			end
			pending <= expected_avgs.size();
		end
	end

endmodule

`default_nettype wire

[tb/sv/tb_spectrum_band_averager.sv]
// Testbench top for the spectrum band averager: drives frames of bins with random
// gaps and output stalls, and gives the verdict from the checker's failure count.
// Depends on sba_pkg, spectrum_band_averager, sba_band_checker.
`default_nettype none

module tb_spectrum_band_averager;
	import sba_pkg::*;

	localparam int RANDOM_BINS = 115;

	typedef enum {MAG_MIXED, MAG_FULL, MAG_ZERO} mag_style_t;

	logic clk;
	logic arst_n;
	logic bin_valid;
	logic bin_stall;
	bin_t bin;
	logic avg_valid;
	logic avg_stall;
	avg_t avg;

	int fails;
	int pending;
	int checked;
	int bins_sent;
	int frames_sent;
	int idle_pct;
	bit calm;

	spectrum_band_averager dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bin_valid (bin_valid),
		.bin_stall (bin_stall),
		.bin       (bin),
		.avg_valid (avg_valid),
		.avg_stall (avg_stall),
		.avg       (avg)
	);

	sba_band_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.bin_valid  (bin_valid),
		.bin_stall  (bin_stall),
		.bin        (bin),
		.avg_valid  (avg_valid),
		.avg_stall  (avg_stall),
		.avg        (avg),
		.fail_count (fails),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_bin(input logic [14:0] mag, input logic last);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(1, 100) <= idle_pct)
			gap = $urandom_range(1, 17);
		if (gap != 0) begin
			bin_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bin_valid <= 1'b1;
		bin       <= {mag, last};
		@(posedge clk);
		while (bin_stall)
			@(posedge clk);
		bins_sent++;
	endtask

	task automatic send_frame(input int len, input mag_style_t style);
		logic [14:0] mag;
		for (int i = 0; i < len; i++) begin
			case (style)
				MAG_FULL: mag = '1;
				MAG_ZERO: mag = '0;
				default: begin
					case ($urandom_range(0, 7))
						0: mag = '0;
						1: mag = '1;
						2: mag = 15'(1) << $urandom_range(0, 14);
						default: mag = 15'($urandom_range(0, 32767));
					endcase
				end
			endcase
			send_bin(mag, i == len - 1);
		end
		frames_sent++;
	endtask

	// hold the bin side until every band result is back
	task automatic drain_results();
		bin_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		avg_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				avg_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			avg_stall <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	initial begin
		int first_random;
		int rand_frames;
		int len;
		mag_style_t style;
		arst_n      <= 1'b0;
		bin_valid   <= 1'b0;
		bin         <= '0;
		bins_sent   = 0;
		frames_sent = 0;
		idle_pct    = 0;
		calm        = 1'b0;
		rand_frames = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_frame(1, MAG_FULL);    // frame end on bin 0: all bands empty
		send_frame(7, MAG_FULL);    // frame end bin is the first band bin
		idle_pct = 30;
		send_frame(12, MAG_MIXED);
		send_frame(75, MAG_FULL);   // lower seven bands at full scale
		drain_results();
		send_frame(20, MAG_ZERO);

		first_random = bins_sent;
		while (bins_sent - first_random < RANDOM_BINS || rand_frames < 6) begin
			if (bins_sent - first_random >= RANDOM_BINS * 4 / 5) begin
				calm     = 1'b1;
				idle_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 15;
					default: idle_pct = 50;
				endcase
			end
			if ($urandom_range(0, 99) < 85)
				len = $urandom_range(1, 24);
			else
				len = $urandom_range(25, 60);
			case ($urandom_range(0, 9))
				0: style = MAG_FULL;
				1: style = MAG_ZERO;
				default: style = MAG_MIXED;
			endcase
			send_frame(len, style);
			rand_frames++;
			if (rand_frames == 3)
				drain_results();
		end

		drain_results();
		repeat (50) @(posedge clk);
		$display("Sent %0d bins in %0d frames (short, full-scale, zero and random content)",
			bins_sent, frames_sent);
		$display("Compared %0d band averages with random gaps and output stalls", checked);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

[spectrum_band_averager.f]
+incdir+rtl
rtl/sba_pkg.sv
rtl/sba_ctrl.sv
rtl/sba_datapath.sv
rtl/spectrum_band_averager.sv
tb/sv/sba_band_checker.sv
tb/sv/tb_spectrum_band_averager.sv
